[rtl/core/fntb_pkg.sv]
// shared types and constants of the fan triangle normal and tangent block
package fntb_pkg;

	localparam int unsigned VertexCapacityDef = 65536;

	localparam int DiffW    = 33;
	localparam int ProdW    = 2 * DiffW;
	localparam int AccW     = ProdW + 1;
	localparam int NumPairs = 7;
	localparam int NumSteps = 2 * NumPairs;
	localparam int TagW     = 3;
	localparam int QuoW     = 32;

	typedef struct packed {
		logic               starts_face;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] tex_u;
		logic signed [31:0] tex_v;
	} vtx_t;

	typedef struct packed {
		logic [15:0]        vertex_id;
		logic               has_triangle;
		logic [15:0]        first_id;
		logic [15:0]        previous_id;
		logic               patch_earlier;
		logic signed [63:0] normal_x;
		logic signed [63:0] normal_y;
		logic signed [63:0] normal_z;
		logic signed [31:0] tangent_x;
		logic signed [31:0] tangent_y;
		logic signed [31:0] tangent_z;
		logic               uv_degenerate;
	} res_t;

	typedef struct packed {
		logic            valid;
		logic            second;
		logic [TagW-1:0] tag;
	} mac_ctl_t;

endpackage

[rtl/core/fntb_mac.sv]
// shared multiplier with product pair subtraction
module fntb_mac import fntb_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  mac_ctl_t               op,
	input  logic signed [DiffW-1:0] a,
	input  logic signed [DiffW-1:0] b,
	output logic                   res_valid,
	output logic [TagW-1:0]        res_tag,
	output logic signed [AccW-1:0] res_val
);

	mac_ctl_t                ctl_s1, ctl_s2;
	logic signed [DiffW-1:0] a_s1, b_s1;
	logic signed [ProdW-1:0] prod_s2;
	logic signed [ProdW-1:0] acc_q;
	logic                    res_valid_q;
	logic [TagW-1:0]         res_tag_q;
	logic signed [AccW-1:0]  res_val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1      <= '0;
			ctl_s2      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			ctl_s1      <= op;
			ctl_s2      <= ctl_s1;
			res_valid_q <= ctl_s2.valid && ctl_s2.second;
		end
	end

	always_ff @(posedge clk) begin
		a_s1    <= a;
		b_s1    <= b;
		prod_s2 <= a_s1 * b_s1;
		if (ctl_s2.valid && !ctl_s2.second) begin
			acc_q <= prod_s2;
		end
		if (ctl_s2.valid && ctl_s2.second) begin
			res_val_q <= AccW'(acc_q) - AccW'(prod_s2);
			res_tag_q <= ctl_s2.tag;
		end
	end

	assign res_valid = res_valid_q;
	assign res_tag   = res_tag_q;
	assign res_val   = res_val_q;

endmodule

[rtl/core/fntb_div.sv]
// iterative signed divider, one quotient bit a cycle, saturating to 32 bits
module fntb_div import fntb_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic signed [AccW-1:0] num,
	input  logic signed [AccW-1:0] den,
	output logic                   done,
	output logic signed [QuoW-1:0] quo
);

	localparam int UnW  = AccW + 16;
	localparam int CntW = $clog2(QuoW);

	typedef enum logic [3:0] {
		D_IDLE = 4'b0001,
		D_CHK  = 4'b0010,
		D_ITER = 4'b0100,
		D_FIN  = 4'b1000
	} dstate_t;

	dstate_t               state_q;
	logic [UnW-1:0]        un_q;
	logic [AccW-1:0]       ud_q;
	logic                  neg_q;
	logic                  ovf_q;
	logic [AccW-1:0]       rem_q;
	logic [QuoW-1:0]       quo_q;
	logic [CntW-1:0]       cnt_q;
	logic                  done_q;
	logic signed [QuoW-1:0] res_q;

	logic [AccW-1:0] num_mag, den_mag;
	logic [AccW:0]   trial;
	logic            take;

	always_comb begin
		num_mag = num[AccW-1] ? AccW'(-num) : AccW'(num);
		den_mag = den[AccW-1] ? AccW'(-den) : AccW'(den);
		trial   = {rem_q, quo_q[QuoW-1]};
		take    = trial >= {1'b0, ud_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				D_IDLE: begin
					if (start) begin
						state_q <= D_CHK;
					end
				end
				D_CHK: begin
					cnt_q   <= '0;
					state_q <= ({16'b0, un_q} >= {ud_q, 32'b0}) ? D_FIN : D_ITER;
				end
				D_ITER: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CntW'(QuoW - 1)) begin
						state_q <= D_FIN;
					end
				end
				D_FIN: begin
					done_q  <= 1'b1;
					state_q <= D_IDLE;
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			D_IDLE: begin
				un_q  <= {num_mag, 16'b0};
				ud_q  <= den_mag;
				neg_q <= num[AccW-1] ^ den[AccW-1];
			end
			D_CHK: begin
				ovf_q <= {16'b0, un_q} >= {ud_q, 32'b0};
				rem_q <= AccW'(un_q[UnW-1:QuoW]);
				quo_q <= un_q[QuoW-1:0];
			end
			D_ITER: begin
				if (take) begin
					rem_q <= AccW'(trial - {1'b0, ud_q});
				end else begin
					rem_q <= trial[AccW-1:0];
				end
				quo_q <= {quo_q[QuoW-2:0], take};
			end
			D_FIN: begin
				if (neg_q) begin
					if (ovf_q || quo_q > {1'b1, {(QuoW-1){1'b0}}}) begin
						res_q <= {1'b1, {(QuoW-1){1'b0}}};
					end else begin
						res_q <= -quo_q;
					end
				end else begin
					if (ovf_q || quo_q[QuoW-1]) begin
						res_q <= {1'b0, {(QuoW-1){1'b1}}};
					end else begin
						res_q <= quo_q;
					end
				end
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign quo  = res_q;

endmodule

[rtl/core/fan_triangle_normal_tangent.sv]
// top level: fan triangulation with face normal and uv tangent per triangle
// a vertex without a triangle goes from idle straight to the output state
// a triangle vertex runs the multiply steps, then a divide per tangent axis;
// a zero uv determinant skips the divides, an overflowing axis skips the divide iterations
// one request at a time, with the single divider shared by the three axes
// the result register lets the next request in while a result waits
// reset clears face count, ids and stored vertices to zero; no clearing pass
module fan_triangle_normal_tangent import fntb_pkg::*; #(
	parameter int unsigned VERTEX_CAPACITY = VertexCapacityDef
) (
	input  logic clk,
	input  logic arst_n,
	input  logic vtx_valid,
	output logic vtx_stall,
	input  vtx_t vtx,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	localparam int IdW = $clog2(VERTEX_CAPACITY);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_MUL   = 6'b000010,
		S_WAIT  = 6'b000100,
		S_DIV   = 6'b001000,
		S_DWAIT = 6'b010000,
		S_OUT   = 6'b100000
	} state_t;

	// ids are handed out at the low 16 bits of the running count
	function automatic logic [15:0] id16(input logic [IdW-1:0] v);
		logic [31:0] t;
		t = 32'(v);
		return t[15:0];
	endfunction

	// clamp a 67-bit pair difference into the 64-bit normal field
	function automatic logic signed [63:0] sat64(input logic signed [AccW-1:0] v);
		if (v[AccW-1:63] == '0 || v[AccW-1:63] == '1) begin
			return v[63:0];
		end
		return v[AccW-1] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
	endfunction

	state_t state_q;

	// face state
	logic signed [31:0] fpos_q [3];
	logic signed [31:0] ftex_q [2];
	logic signed [31:0] ppos_q [3];
	logic signed [31:0] ptex_q [2];
	logic [1:0]         fvc_q;
	logic [IdW-1:0]     fid_q;
	logic [IdW-1:0]     nid_q;

	// per-request working registers
	logic signed [DiffW-1:0] e1_q [3];
	logic signed [DiffW-1:0] e2_q [3];
	logic signed [DiffW-1:0] du1_q, dv1_q, du2_q, dv2_q;
	logic                    tri_q, patch_q, degen_q;
	logic [IdW-1:0]          vid_q, fidr_q, pid_q;
	logic signed [AccW-1:0]  acc_q [NumPairs];
	logic signed [QuoW-1:0]  tan_q [3];
	logic [3:0]              step_q;
	logic [1:0]              comp_q;

	logic                 res_valid_q;
	res_t                 res_q;

	logic                 accept;
	logic [1:0]           n_cnt;
	logic signed [31:0]   pin [3];
	logic signed [31:0]   tin [2];

	mac_ctl_t                mac_op;
	logic signed [DiffW-1:0] op_a, op_b;
	logic [TagW-1:0]         pair;
	logic [1:0]              axis;
	logic                    mac_valid;
	logic [TagW-1:0]         mac_tag;
	logic signed [AccW-1:0]  mac_val;

	logic                    div_start, div_done;
	logic signed [QuoW-1:0]  div_quo;
	logic signed [AccW-1:0]  div_num;
	logic                    out_free;

	assign accept    = vtx_valid && !vtx_stall;
	assign vtx_stall = (state_q != S_IDLE);
	assign n_cnt     = vtx.starts_face ? 2'd0 : fvc_q;
	assign out_free  = !res_valid_q || !res_stall;
	assign pin[0]    = vtx.pos_x;
	assign pin[1]    = vtx.pos_y;
	assign pin[2]    = vtx.pos_z;
	assign tin[0]    = vtx.tex_u;
	assign tin[1]    = vtx.tex_v;

	// operand selection: each pair of steps forms one product difference
	always_comb begin
		pair = step_q[3:1];
		axis = 2'(pair - TagW'(4));
		op_a = '0;
		op_b = '0;
		case (pair)
			3'd0: begin
				op_a = step_q[0] ? e1_q[2] : e1_q[1];
				op_b = step_q[0] ? e2_q[1] : e2_q[2];
			end
			3'd1: begin
				op_a = step_q[0] ? e1_q[0] : e1_q[2];
				op_b = step_q[0] ? e2_q[2] : e2_q[0];
			end
			3'd2: begin
				op_a = step_q[0] ? e1_q[1] : e1_q[0];
				op_b = step_q[0] ? e2_q[0] : e2_q[1];
			end
			3'd3: begin
				op_a = step_q[0] ? du2_q : du1_q;
				op_b = step_q[0] ? dv1_q : dv2_q;
			end
			3'd4, 3'd5, 3'd6: begin
				// tangent numerators: e1 * dv2 - e2 * dv1 per axis
				op_a = step_q[0] ? e2_q[axis] : e1_q[axis];
				op_b = step_q[0] ? dv1_q : dv2_q;
			end
			default: ;
		endcase
		mac_op.valid  = (state_q == S_MUL);
		mac_op.second = step_q[0];
		mac_op.tag    = pair;
	end

	fntb_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (mac_op),
		.a         (op_a),
		.b         (op_b),
		.res_valid (mac_valid),
		.res_tag   (mac_tag),
		.res_val   (mac_val)
	);

	assign div_start = (state_q == S_DIV);
	assign div_num   = acc_q[3'(comp_q) + TagW'(4)];

	fntb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (acc_q[3]),
		.done   (div_done),
		.quo    (div_quo)
	);

	// sequencer and face state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
			fvc_q       <= '0;
			fid_q       <= '0;
			nid_q       <= '0;
			step_q      <= '0;
			comp_q      <= '0;
			for (int i = 0; i < 3; i++) begin
				fpos_q[i] <= '0;
				ppos_q[i] <= '0;
			end
			for (int i = 0; i < 2; i++) begin
				ftex_q[i] <= '0;
				ptex_q[i] <= '0;
			end
		end else begin
			// a new result is loaded, a stalled one is held
			res_valid_q <= (state_q == S_OUT && out_free) || (res_valid_q && res_stall);
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (n_cnt == 2'd0) begin
							for (int i = 0; i < 3; i++) begin
								fpos_q[i] <= pin[i];
							end
							ftex_q[0] <= tin[0];
							ftex_q[1] <= tin[1];
							fid_q     <= nid_q;
						end
						for (int i = 0; i < 3; i++) begin
							ppos_q[i] <= pin[i];
						end
						ptex_q[0] <= tin[0];
						ptex_q[1] <= tin[1];
						fvc_q     <= (n_cnt == 2'd3) ? 2'd3 : n_cnt + 2'd1;
						nid_q     <= (nid_q == IdW'(VERTEX_CAPACITY - 1)) ? '0 : nid_q + 1'b1;
						step_q    <= '0;
						comp_q    <= '0;
						state_q   <= (n_cnt >= 2'd2) ? S_MUL : S_OUT;
					end
				end
				S_MUL: begin
					step_q <= step_q + 1'b1;
					if (step_q == 4'(NumSteps - 1)) begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (mac_valid && mac_tag == TagW'(NumPairs - 1)) begin
						state_q <= (acc_q[3] == '0) ? S_OUT : S_DIV;
					end
				end
				S_DIV: begin
					state_q <= S_DWAIT;
				end
				S_DWAIT: begin
					if (div_done) begin
						comp_q  <= comp_q + 1'b1;
						state_q <= (comp_q == 2'd2) ? S_OUT : S_DIV;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// working registers and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < 3; i++) begin
				e1_q[i] <= DiffW'(ppos_q[i]) - DiffW'(fpos_q[i]);
				e2_q[i] <= DiffW'(pin[i]) - DiffW'(fpos_q[i]);
			end
			du1_q   <= DiffW'(ptex_q[0]) - DiffW'(ftex_q[0]);
			dv1_q   <= DiffW'(ptex_q[1]) - DiffW'(ftex_q[1]);
			du2_q   <= DiffW'(tin[0]) - DiffW'(ftex_q[0]);
			dv2_q   <= DiffW'(tin[1]) - DiffW'(ftex_q[1]);
			tri_q   <= (n_cnt >= 2'd2);
			patch_q <= (n_cnt == 2'd2);
			vid_q   <= nid_q;
			fidr_q  <= fid_q;
			pid_q   <= (nid_q == '0) ? IdW'(VERTEX_CAPACITY - 1) : nid_q - 1'b1;
			degen_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				tan_q[i] <= '0;
			end
		end
		if (mac_valid) begin
			acc_q[mac_tag] <= mac_val;
		end
		if (state_q == S_WAIT && mac_valid && mac_tag == TagW'(NumPairs - 1)) begin
			degen_q <= (acc_q[3] == '0);
		end
		if (state_q == S_DWAIT && div_done) begin
			tan_q[comp_q] <= div_quo;
		end
		if (state_q == S_OUT && out_free) begin
			res_q.vertex_id     <= id16(vid_q);
			res_q.has_triangle  <= tri_q;
			res_q.first_id      <= tri_q ? id16(fidr_q) : '0;
			res_q.previous_id   <= tri_q ? id16(pid_q) : '0;
			res_q.patch_earlier <= tri_q && patch_q;
			res_q.normal_x      <= tri_q ? sat64(acc_q[0]) : '0;
			res_q.normal_y      <= tri_q ? sat64(acc_q[1]) : '0;
			res_q.normal_z      <= tri_q ? sat64(acc_q[2]) : '0;
			res_q.tangent_x     <= tan_q[0];
			res_q.tangent_y     <= tan_q[1];
			res_q.tangent_z     <= tan_q[2];
			res_q.uv_degenerate <= tri_q && degen_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

[sim/tb_top.sv]
// testbench for the fan triangle normal and tangent block
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import fntb_pkg::*;

	localparam int unsigned Capacity = VertexCapacityDef;
	localparam int WatchdogLimit = 20000;

	logic clk;
	logic arst_n;
	logic vtx_valid;
	logic vtx_stall;
	vtx_t vtx;
	logic res_valid;
	logic res_stall;
	res_t res;

	fan_triangle_normal_tangent #(
		.VERTEX_CAPACITY(Capacity)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.vtx_valid(vtx_valid),
		.vtx_stall(vtx_stall),
		.vtx(vtx),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	// predictor state, mirrors the block after reset
	logic signed [31:0] fan_first_pos [3];
	logic signed [31:0] fan_first_uv [2];
	logic signed [31:0] fan_prev_pos [3];
	logic signed [31:0] fan_prev_uv [2];
	logic [1:0]         fan_count;
	logic [15:0]        fan_first_id;
	logic [15:0]        fan_next_id;

	vtx_t pending_vertices [$];
	res_t expected_results [$];

	int  mismatches;
	int  accepted_vertices;
	bit  stimulus_done;
	bit  hold_results;
	int  idle_cycles;
	bit  vtx_taken;

	// clamp a wide signed value into 64 bits
	function automatic logic signed [63:0] clamp64(logic signed [135:0] v);
		if (v > 136'sh7FFFFFFFFFFFFFFF)
			return 64'sh7FFFFFFFFFFFFFFF;
		if (v < -136'sh8000000000000000)
			return 64'sh8000000000000000;
		return v[63:0];
	endfunction

	function automatic logic signed [31:0] clamp32(logic signed [135:0] v);
		if (v > 136'sh7FFFFFFF)
			return 32'sh7FFFFFFF;
		if (v < -136'sh80000000)
			return 32'sh80000000;
		return v[31:0];
	endfunction

	// fan step: updates the face state and gives the result for one vertex
	function automatic res_t fan_step(vtx_t v);
		res_t r;
		logic signed [31:0] p [3];
		logic signed [31:0] t [2];
		logic signed [135:0] e1 [3];
		logic signed [135:0] e2 [3];
		logic signed [135:0] du1, dv1, du2, dv2, det, num, q;
		logic [1:0] n;
		logic [15:0] id;
		p[0] = v.pos_x;
		p[1] = v.pos_y;
		p[2] = v.pos_z;
		t[0] = v.tex_u;
		t[1] = v.tex_v;
		id = fan_next_id;
		if (v.starts_face)
			fan_count = 0;
		n = fan_count;
		r = '0;
		r.vertex_id = id;
		if (n == 0) begin
			fan_first_pos = p;
			fan_first_uv = t;
			fan_first_id = id;
		end else if (n >= 2) begin
			for (int i = 0; i < 3; i++) begin
				e1[i] = 136'(fan_prev_pos[i]) - 136'(fan_first_pos[i]);
				e2[i] = 136'(p[i]) - 136'(fan_first_pos[i]);
			end
			du1 = 136'(fan_prev_uv[0]) - 136'(fan_first_uv[0]);
			dv1 = 136'(fan_prev_uv[1]) - 136'(fan_first_uv[1]);
			du2 = 136'(t[0]) - 136'(fan_first_uv[0]);
			dv2 = 136'(t[1]) - 136'(fan_first_uv[1]);
			r.has_triangle = 1'b1;
			r.first_id = fan_first_id;
			r.previous_id = (id == 0) ? 16'(Capacity - 1) : id - 16'd1;
			r.patch_earlier = (n == 2);
			r.normal_x = clamp64(e1[1] * e2[2] - e1[2] * e2[1]);
			r.normal_y = clamp64(e1[2] * e2[0] - e1[0] * e2[2]);
			r.normal_z = clamp64(e1[0] * e2[1] - e1[1] * e2[0]);
			det = du1 * dv2 - du2 * dv1;
			if (det == 0) begin
				r.uv_degenerate = 1'b1;
			end else begin
				for (int i = 0; i < 3; i++) begin
					num = (e1[i] * dv2 - e2[i] * dv1) <<< 16;
					// signed division truncates toward zero
					q = num / det;
					case (i)
						0: r.tangent_x = clamp32(q);
						1: r.tangent_y = clamp32(q);
						default: r.tangent_z = clamp32(q);
					endcase
				end
			end
		end
		fan_prev_pos = p;
		fan_prev_uv = t;
		if (fan_count < 3)
			fan_count++;
		fan_next_id = (32'(id) + 1 >= Capacity) ? 16'd0 : id + 16'd1;
		return r;
	endfunction

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// request taken at a rising edge, seen by the driver at the falling edge
	always @(posedge clk)
		vtx_taken <= arst_n && vtx_valid && !vtx_stall;

	// driver: one request at a time from the pending queue, random gaps
	int send_gap;
	bit sender_paused;
	initial begin
		vtx_valid = 1'b0;
		vtx = '0;
		send_gap = 0;
	end
	always @(negedge clk) begin
		if (arst_n) begin
			if (vtx_taken) begin
				// request taken at the last rising edge
				accepted_vertices++;
				expected_results.insert(expected_results.size(), fan_step(vtx));
				send_gap = $urandom_range(0, 3);
				if (send_gap != 0 || pending_vertices.size() == 0 || sender_paused)
					vtx_valid <= 1'b0;
				else begin
					vtx <= pending_vertices.pop_front();
					vtx_valid <= 1'b1;
				end
			end else if (!vtx_valid) begin
				if (send_gap > 0)
					send_gap--;
				else if (pending_vertices.size() != 0 && !sender_paused) begin
					vtx <= pending_vertices.pop_front();
					vtx_valid <= 1'b1;
				end
			end
		end
	end

	// receiver stall: random per result, or a long hold-off when asked
	int stall_left;
	initial begin
		res_stall = 1'b1;
		stall_left = 0;
	end
	always @(negedge clk) begin
		if (hold_results)
			res_stall <= 1'b1;
		else if (stall_left > 0) begin
			stall_left--;
			res_stall <= 1'b1;
		end else if (res_valid && res_stall == 1'b0) begin
			// a result moves at the next edge, so draw the wait for the one after it
			stall_left = $urandom_range(0, 3);
			res_stall <= (stall_left != 0);
		end else
			res_stall <= 1'b0;
	end

	// monitor: compares each result with the oldest expectation
	res_t want;
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: %p", res);
			end else begin
				want = expected_results.pop_front();
				if (res !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch vertex %0d\n  expected %p\n  actual   %p",
							want.vertex_id, want, res);
				end
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (!arst_n || (vtx_valid && !vtx_stall) || (res_valid && !res_stall))
			idle_cycles <= 0;
		else if (pending_vertices.size() != 0 || expected_results.size() != 0
				|| vtx_valid)
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchdogLimit) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2: return 32'($urandom_range(0, 8)) << 16;
			3: return $urandom();
			default: return 32'($signed($urandom_range(0, 40'hFFFFF)) - 20'sh80000);
		endcase
	endfunction

	function automatic vtx_t make_vertex(logic sf, logic [31:0] x, logic [31:0] y,
			logic [31:0] z, logic [31:0] u, logic [31:0] w);
		vtx_t v;
		v.starts_face = sf;
		v.pos_x = x;
		v.pos_y = y;
		v.pos_z = z;
		v.tex_u = u;
		v.tex_v = w;
		return v;
	endfunction

	task automatic add_vertex(vtx_t v);
		pending_vertices.insert(pending_vertices.size(), v);
	endtask

	task automatic wait_drained();
		while (pending_vertices.size() != 0 || vtx_valid || expected_results.size() != 0)
			@(posedge clk);
	endtask

	// stimulus
	int face_len;
	int total;
	initial begin
		arst_n = 1'b0;
		mismatches = 0;
		accepted_vertices = 0;
		stimulus_done = 1'b0;
		hold_results = 1'b0;
		sender_paused = 1'b0;
		idle_cycles = 0;
		fan_first_pos = '{0, 0, 0};
		fan_prev_pos = '{0, 0, 0};
		fan_first_uv = '{0, 0};
		fan_prev_uv = '{0, 0};
		fan_count = 0;
		fan_first_id = 0;
		fan_next_id = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// first vertex after reset starts a face without the flag
		add_vertex(make_vertex(0, 0, 0, 0, 0, 0));
		add_vertex(make_vertex(0, 32'h10000, 0, 0, 32'h10000, 0));
		// plain unit triangle, then a fan continuation
		add_vertex(make_vertex(0, 0, 32'h10000, 0, 0, 32'h10000));
		add_vertex(make_vertex(0, 32'hFFFF0000, 32'h10000, 32'h20000,
			32'h8000, 32'h30000));
		// zero uv determinant: all texcoords equal
		add_vertex(make_vertex(1, 5, 6, 7, 32'h1234, 32'h5678));
		add_vertex(make_vertex(0, 32'h30000, 9, 1, 32'h1234, 32'h5678));
		add_vertex(make_vertex(0, 1, 32'h40000, 2, 32'h1234, 32'h5678));
		// extremes: normal and tangent saturation both ways
		add_vertex(make_vertex(1, 32'h80000000, 32'h80000000,
			32'h80000000, 32'h80000000, 32'h80000000));
		add_vertex(make_vertex(0, 32'h7FFFFFFF, 32'h80000000,
			32'h7FFFFFFF, 32'h80000001, 32'h80000000));
		add_vertex(make_vertex(0, 32'h80000000, 32'h7FFFFFFF,
			32'h7FFFFFFF, 32'h80000000, 32'h80000001));
		add_vertex(make_vertex(0, 32'h7FFFFFFF, 32'h7FFFFFFF,
			32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF));
		add_vertex(make_vertex(1, 32'h7FFFFFFF, 32'h7FFFFFFF,
			32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
		add_vertex(make_vertex(0, 32'h80000000, 32'h80000000,
			32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFE));
		add_vertex(make_vertex(0, 32'h80000000, 32'h7FFFFFFF,
			32'h80000000, 32'h7FFFFFFE, 32'h80000000));
		// a face restarted after two vertices, and a single-vertex face
		add_vertex(make_vertex(1, 1, 2, 3, 4, 5));
		add_vertex(make_vertex(1, 32'hFFFFFFFF, 32'hFFFFFFFF,
			32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF));
		add_vertex(make_vertex(0, 0, 0, 0, 0, 0));
		add_vertex(make_vertex(1, 0, 0, 0, 0, 0));
		wait_drained();

		// long receiver hold-off while the sender keeps offering
		hold_results = 1'b1;
		for (int i = 0; i < 8; i++)
			add_vertex(make_vertex(i == 0, rand_word(), rand_word(),
				rand_word(), rand_word(), rand_word()));
		repeat (600) @(posedge clk);
		hold_results = 1'b0;
		wait_drained();

		// random faces; mostly well formed fans, some short or broken faces
		total = 26;
		while (total < 950) begin
			face_len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2)
				: $urandom_range(3, 8);
			for (int i = 0; i < face_len; i++) begin
				add_vertex(make_vertex(i == 0 || $urandom_range(0, 30) == 0,
					rand_word(), rand_word(), rand_word(),
					($urandom_range(0, 7) == 0) ? 32'h10000 : rand_word(),
					($urandom_range(0, 7) == 0) ? 32'h20000 : rand_word()));
				total++;
			end
			// sender pause until every result is back
			if (total > 500 && total < 510) begin
				sender_paused = 1'b1;
				while (vtx_valid || expected_results.size() != 0)
					@(posedge clk);
				sender_paused = 1'b0;
			end
			while (pending_vertices.size() > 16)
				@(posedge clk);
		end
		wait_drained();
		repeat (200) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
